@@ hdl/host_level_decay_table_assert.svh @@
// assertion macros for the host level decay table checker
`ifndef HOST_LEVEL_DECAY_TABLE_ASSERT_SVH
`define HOST_LEVEL_DECAY_TABLE_ASSERT_SVH

// checked while out of reset
`define HLDT_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: assertion failed");

// checked at every edge, also during reset
`define HLDT_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

@@ hdl/hldt_pkg.sv @@
// shared types, widths and codes of the host level decay table
`default_nettype none

package hldt_pkg;

  localparam int TABLE_DEPTH = 64;

  localparam int ACTION_W = 2;
  localparam int ADDR_W   = 32;
  localparam int LEVEL_W  = 32;
  localparam int AMOUNT_W = 16;
  localparam int STATUS_W = 2;

  localparam int IN_DATA_W  = ADDR_W + LEVEL_W + LEVEL_W + AMOUNT_W;
  localparam int IN_USER_W  = ACTION_W + 1;
  localparam int OUT_DATA_W = LEVEL_W;
  localparam int OUT_USER_W = STATUS_W;

  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_DECAY  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ   = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  localparam logic [AMOUNT_W-1:0] RECOVERY_RESET = 16'd1;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [ADDR_W-1:0]   host_address;
    logic                level_select;
    logic [LEVEL_W-1:0]  compromise_init;
    logic [LEVEL_W-1:0]  attack_init;
    logic [AMOUNT_W-1:0] add_amount;
    logic                done;
    logic [LEVEL_W-1:0]  level;
  } item_t;

endpackage

`default_nettype wire

@@ hdl/hldt_cell.sv @@
// one table entry: holds a host and its levels, applies the passing item
`default_nettype none

module hldt_cell (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            adv_i,
  input  wire  [hldt_pkg::AMOUNT_W-1:0]  recovery_i,
  input  wire                            vld_i,
  input  hldt_pkg::item_t                item_i,
  output logic                           vld_o,
  output hldt_pkg::item_t                item_o
);
  import hldt_pkg::*;

  logic                valid_q, valid_d;
  logic [ADDR_W-1:0]   addr_q, addr_d;
  logic [LEVEL_W-1:0]  cmp_q, cmp_d;
  logic [LEVEL_W-1:0]  atk_q, atk_d;
  logic                vld_q;
  item_t               item_q, item_d;

  logic                hit;
  logic [LEVEL_W-1:0]  sel_lvl;
  logic [LEVEL_W:0]    sum;
  logic [LEVEL_W-1:0]  sat;
  logic [LEVEL_W-1:0]  rec;
  logic [LEVEL_W-1:0]  cmp_dec;
  logic [LEVEL_W-1:0]  atk_dec;

  always_comb begin
    hit     = valid_q && (addr_q == item_i.host_address);
    sel_lvl = item_i.level_select ? atk_q : cmp_q;
    sum     = {1'b0, sel_lvl} + {{(LEVEL_W+1-AMOUNT_W){1'b0}}, item_i.add_amount};
    sat     = sum[LEVEL_W] ? {LEVEL_W{1'b1}} : sum[LEVEL_W-1:0];
    rec     = {{(LEVEL_W-AMOUNT_W){1'b0}}, recovery_i};
    cmp_dec = (cmp_q > rec) ? (cmp_q - rec) : '0;
    atk_dec = (atk_q > rec) ? (atk_q - rec) : '0;
  end

  always_comb begin
    item_d  = item_i;
    valid_d = valid_q;
    addr_d  = addr_q;
    cmp_d   = cmp_q;
    atk_d   = atk_q;
    if (vld_i) begin
      case (item_i.action)
        ACT_INSERT: begin
          if (!item_i.done && !valid_q) begin
            valid_d     = 1'b1;
            addr_d      = item_i.host_address;
            cmp_d       = item_i.compromise_init;
            atk_d       = item_i.attack_init;
            item_d.done = 1'b1;
          end
        end
        ACT_DECAY: begin
          if (valid_q) begin
            cmp_d = cmp_dec;
            atk_d = atk_dec;
          end
        end
        ACT_READ: begin
          if (!item_i.done && hit) begin
            item_d.done  = 1'b1;
            item_d.level = sel_lvl;
          end
        end
        ACT_ADD: begin
          if (!item_i.done && hit) begin
            item_d.done = 1'b1;
            if (item_i.level_select) begin
              atk_d = sat;
            end else begin
              cmp_d = sat;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      vld_q   <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_d;
      vld_q   <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      addr_q <= addr_d;
      cmp_q  <= cmp_d;
      atk_q  <= atk_d;
      item_q <= item_d;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

`default_nettype wire

@@ hdl/host_level_decay_table.sv @@
// top level of the host level decay table: cell chain and output register
//
// Input beats arrive on s_axis: tuser carries the action and the level
// select, tdata the address, both initial levels and the add amount. Each
// beat gives exactly one result beat on m_axis: tuser holds the status,
// tdata the level read (zero for anything but a read that found its host).
// The table is a row of TABLE_DEPTH cells, one entry each. A beat moves one
// cell per cycle and beats may follow each other in every cycle, one result
// per cycle; but when the receiver stalls a waiting result, the whole chain
// holds and s_axis_tready goes low. The user must write the recovery amount
// on the cfg channel only while the block is idle; the block does not
// enforce this. The cfg channel is always ready. Reset empties the table,
// sets the recovery amount to 1 and drops any beat in flight.
`default_nettype none

module host_level_decay_table (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  // host_address, compromise_init, attack_init, add_amount
  input  wire  [hldt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // action, level_select
  input  wire  [hldt_pkg::IN_USER_W-1:0]    s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  // level_value
  output logic [hldt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // status
  output logic [hldt_pkg::OUT_USER_W-1:0]   m_axis_tuser,
  input  wire                               cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire  [hldt_pkg::AMOUNT_W-1:0]     cfg_data_i
);
  import hldt_pkg::*;

  logic                  adv;
  logic [AMOUNT_W-1:0]   recovery_q;
  logic                  out_vld_q;
  logic [STATUS_W-1:0]   status_q, status_d;
  logic [LEVEL_W-1:0]    level_q, level_d;

  logic                  vld_chain  [TABLE_DEPTH+1];
  item_t                 item_chain [TABLE_DEPTH+1];
  item_t                 last;

  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    item_chain[0].action          = s_axis_tuser[ACTION_W-1:0];
    item_chain[0].level_select    = s_axis_tuser[ACTION_W];
    item_chain[0].host_address    = s_axis_tdata[ADDR_W-1:0];
    item_chain[0].compromise_init = s_axis_tdata[ADDR_W+LEVEL_W-1:ADDR_W];
    item_chain[0].attack_init     = s_axis_tdata[ADDR_W+2*LEVEL_W-1:ADDR_W+LEVEL_W];
    item_chain[0].add_amount      = s_axis_tdata[IN_DATA_W-1:ADDR_W+2*LEVEL_W];
    item_chain[0].done            = 1'b0;
    item_chain[0].level           = '0;
  end
  assign vld_chain[0] = s_axis_tvalid;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    hldt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .adv_i      (adv),
      .recovery_i (recovery_q),
      .vld_i      (vld_chain[i]),
      .item_i     (item_chain[i]),
      .vld_o      (vld_chain[i+1]),
      .item_o     (item_chain[i+1])
    );
  end

  assign last = item_chain[TABLE_DEPTH];

  always_comb begin
    status_d = ST_OK;
    level_d  = '0;
    case (last.action)
      ACT_INSERT: status_d = last.done ? ST_OK : ST_FULL;
      ACT_DECAY:  status_d = ST_OK;
      ACT_READ: begin
        status_d = last.done ? ST_OK : ST_NOT_FOUND;
        level_d  = last.done ? last.level : '0;
      end
      ACT_ADD:    status_d = last.done ? ST_OK : ST_NOT_FOUND;
      default:    status_d = ST_OK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recovery_q <= RECOVERY_RESET;
    end else if (cfg_valid_i) begin
      recovery_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= vld_chain[TABLE_DEPTH];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      status_q <= status_d;
      level_q  <= level_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = level_q;
  assign m_axis_tuser  = status_q;

endmodule

`default_nettype wire

@@ hdl/hldt_checker.sv @@
// port level checks of the host level decay table, bound to the top level
`default_nettype none

`include "host_level_decay_table_assert.svh"

module hldt_checker (
  input wire                             clk_i,
  input wire                             rst_ni,
  input wire                             s_axis_tready,
  input wire                             m_axis_tvalid,
  input wire                             m_axis_tready,
  input wire [hldt_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input wire [hldt_pkg::OUT_USER_W-1:0]  m_axis_tuser
);
  import hldt_pkg::*;

  // a stalled result stays offered
  `HLDT_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)

  // any status but ok carries a zero level
  `HLDT_ASSERT(a_level_zero, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser != ST_OK) |-> m_axis_tdata == '0)

  // input is taken exactly when the output slot frees
  `HLDT_ASSERT(a_in_ready, clk_i, rst_ni, s_axis_tready == (!m_axis_tvalid || m_axis_tready))

  // reset leaves no result offered
  `HLDT_ASSERT_ALWAYS(a_rst_empty, clk_i, !rst_ni |-> !m_axis_tvalid)

endmodule

bind host_level_decay_table hldt_checker u_hldt_checker (.*);

`default_nettype wire
